FILE: rtl/assert_macros.svh
// assertion macros used by the deque top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DWHR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");
`define DWHR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");
`define DWHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define DWHR_ASSERT(lbl, cond)
`define DWHR_ASSERT_IMPL(lbl, ante, cons)
`define DWHR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/dwhr_pkg.sv
// shared constants, command and status codes and state type of the deque
package dwhr_pkg;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_t;

endpackage

FILE: rtl/dwhr_if.sv
// command and result channel interfaces of the deque

interface dwhr_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [dwhr_pkg::CMD_W-1:0]        cmd;
  logic signed [dwhr_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface dwhr_res_if #(
  parameter int COUNT_W = 11
);
  logic                                valid;
  logic                                ready;
  logic signed [dwhr_pkg::DATA_W-1:0]  pop_value;
  logic [dwhr_pkg::STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]                  count_after;

  modport source (output valid, output pop_value, output status, output count_after,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input count_after,
                  output ready);
endinterface

FILE: rtl/dwhr_ram.sv
// generic single-port ram with registered read
module dwhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/deque_with_half_rotation_top.sv
// bounded double-ended queue with a half rotation, built around one ram
//
// in_ch carries one command per transaction: push front, push back, pop front,
// pop back or rotate halves, with push_value for pushes. out_ch returns one
// result per command: pop_value, status (done, empty on pop, full on push)
// and count_after, the element count once the command has taken effect.
// Elements sit in a circular ram of CAPACITY entries; a front pointer and a
// count register track the sequence, so a rotation only moves the pointer.
// Timing: a push, a rotate or a failed pop puts its result in the output
// register at the edge that takes the command, so the result shows in the
// next cycle, when the next command can also be taken if out_ch takes it.
// A successful pop reads the ram, whose read is registered, then passes
// through S_RD, where the read data goes into the output register.
// The output register is the only result storage: while a result waits on
// out_ch the block takes no new command, unless the result is taken in the
// same cycle.
// Reset (rst_n low at a clock edge) empties the queue and drops any pending
// result; the ram contents are not cleared and are never read before written.
module deque_with_half_rotation_top #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  dwhr_cmd_if.sink    in_ch,
  dwhr_res_if.source  out_ch
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  // push_value bits above VALUE_WIDTH are not stored; a pop returns them as zero
  localparam int SW    = (VALUE_WIDTH < dwhr_pkg::DATA_W) ? VALUE_WIDTH : dwhr_pkg::DATA_W;

  dwhr_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                                out_valid_r;
  logic signed [dwhr_pkg::DATA_W-1:0]  out_value_r;
  logic [dwhr_pkg::STATUS_W-1:0]       out_status_r;
  logic [CNT_W-1:0]                    out_count_r;

  logic                          acc;
  logic                          full, empty;
  logic [SUM_W-1:0]              addend, sum, wrapped;
  logic [AW-1:0]                 wrap_idx, front_dec;
  logic [AW-1:0]                 slot;
  logic                          mem_we, mem_re, pop_ok;
  logic [dwhr_pkg::STATUS_W-1:0] status;
  logic [SW-1:0]                 rd_data;

  assign acc   = in_ch.valid && in_ch.ready;
  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  // offset from the front for the slot or new front that the command needs
  always_comb begin
    case (in_ch.cmd)
      dwhr_pkg::CMD_PUSH_BACK: addend = SUM_W'(cnt_r);
      dwhr_pkg::CMD_POP_FRONT: addend = SUM_W'(1);
      dwhr_pkg::CMD_POP_BACK:  addend = SUM_W'(cnt_r) - SUM_W'(1);
      dwhr_pkg::CMD_ROTATE:    addend = SUM_W'(cnt_r >> 1);
      default:                 addend = '0;
    endcase
  end

  // both operands stay below CAPACITY, one subtract wraps the sum
  assign sum       = SUM_W'(front_r) + addend;
  assign wrapped   = (sum >= SUM_W'(CAPACITY)) ? (sum - SUM_W'(CAPACITY)) : sum;
  assign wrap_idx  = wrapped[AW-1:0];
  assign front_dec = (front_r == '0) ? AW'(CAPACITY - 1) : (front_r - AW'(1));

  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    status    = dwhr_pkg::ST_DONE;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    pop_ok    = 1'b0;
    slot      = front_r;
    case (in_ch.cmd)
      dwhr_pkg::CMD_PUSH_FRONT, dwhr_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status = dwhr_pkg::ST_FULL;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (in_ch.cmd == dwhr_pkg::CMD_PUSH_FRONT) begin
            slot      = front_dec;
            front_nxt = front_dec;
          end else begin
            slot = wrap_idx;
          end
        end
      end
      dwhr_pkg::CMD_POP_FRONT, dwhr_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status = dwhr_pkg::ST_EMPTY;
        end else begin
          mem_re  = 1'b1;
          pop_ok  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (in_ch.cmd == dwhr_pkg::CMD_POP_FRONT) begin
            slot      = front_r;
            front_nxt = wrap_idx;
          end else begin
            slot = wrap_idx;
          end
        end
      end
      dwhr_pkg::CMD_ROTATE: begin
        if (cnt_r >= CNT_W'(2)) begin
          front_nxt = wrap_idx;
        end
      end
      default: begin
      end
    endcase
  end

  dwhr_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .en    (acc && (mem_we || mem_re)),
    .we    (mem_we),
    .addr  (slot),
    .wdata (in_ch.push_value[SW-1:0]),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    case (state_r)
      dwhr_pkg::S_IDLE: state_nxt = (acc && pop_ok) ? dwhr_pkg::S_RD : dwhr_pkg::S_IDLE;
      dwhr_pkg::S_RD:   state_nxt = dwhr_pkg::S_IDLE;
      default:          state_nxt = dwhr_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    case (state_r)
      dwhr_pkg::S_IDLE: in_ch.ready = !out_valid_r || out_ch.ready;
      default:          in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwhr_pkg::S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        front_r <= front_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (state_r == dwhr_pkg::S_RD) begin
        out_valid_r <= 1'b1;
      end else if (acc) begin
        // a successful pop waits in S_RD for the ram read
        out_valid_r <= !pop_ok;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_value_r  <= '0;
      out_status_r <= status;
      out_count_r  <= cnt_nxt;
    end else if (state_r == dwhr_pkg::S_RD) begin
      out_value_r <= dwhr_pkg::DATA_W'(rd_data);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pop_value   = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.count_after = out_count_r;

  `include "assert_macros.svh"

  `DWHR_ASSERT(a_count_bound, cnt_r <= CNT_W'(CAPACITY))
  `DWHR_ASSERT(a_front_bound, SUM_W'(front_r) < SUM_W'(CAPACITY))
  `DWHR_ASSERT_IMPL(a_rd_slot_free, state_r == dwhr_pkg::S_RD, !out_valid_r)
  `DWHR_ASSERT_NEXT(a_pop_goes_rd, acc && pop_ok, state_r == dwhr_pkg::S_RD && !in_ch.ready)
  `DWHR_ASSERT_IMPL(a_full_count, out_valid_r && out_status_r == dwhr_pkg::ST_FULL,
                    out_count_r == CNT_W'(CAPACITY))

endmodule
